// ===== rtl/core/crm_pkg.sv =====
// Shared types, constants and codes of the canary rollout monitor.
`timescale 1ns / 1ps
`default_nettype none

package crm_pkg;

    // Field widths
    localparam int REQ_TYPE_W = 3;
    localparam int KEY_W      = 64;
    localparam int TIME_W     = 64;
    localparam int GEN_W      = 64;

    localparam int PCT_W   = 7;
    localparam int DELAY_W = 32;
    localparam int RATIO_W = 17;
    localparam int RUN_W   = 32;

    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int COUNT_WIDTH_DEF = 32;

    // Failure ratio is Q1.16
    localparam int RATIO_SHIFT = 16;

    // Register reset values
    localparam logic [PCT_W-1:0]   PCT_RST   = 7'd5;
    localparam logic [DELAY_W-1:0] DELAY_RST = 32'd30000;
    localparam logic [RATIO_W-1:0] RATIO_RST = 17'd3277;
    localparam logic [RUN_W-1:0]   RUN_RST   = 32'd3;

    // Hash mod 100: fold the key with 2^n mod 100, then a reciprocal multiply
    localparam int FOLD_SUM_W  = 24;
    localparam int FOLD_W      = 19;
    localparam int QUOT_W      = 13;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam int RES_W       = 7;

    localparam logic [FOLD_SUM_W-1:0] FOLD_16 = 24'd36;  // 2^16 mod 100
    localparam logic [FOLD_SUM_W-1:0] FOLD_32 = 24'd96;  // 2^32 mod 100
    localparam logic [FOLD_SUM_W-1:0] FOLD_48 = 24'd56;  // 2^48 mod 100
    localparam logic [FOLD_W-1:0]     FOLD_12 = 19'd96;  // 2^12 mod 100
    localparam logic [RECIP_W-1:0]    RECIP_100 = 20'd671089; // ceil(2^26 / 100)
    localparam logic [FOLD_W-1:0]     MOD_DIV = 19'd100;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_ROUTE  = 3'd0,
        REQ_RECORD = 3'd1,
        REQ_DECIDE = 3'd2,
        REQ_START  = 3'd3,
        REQ_STOP   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_INVALID_ARG  = 2'd1,
        ST_NOT_ACTIVE   = 2'd2,
        ST_COUNTER_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        VERDICT_KEEP     = 2'd0,
        VERDICT_PROMOTE  = 2'd1,
        VERDICT_ROLLBACK = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_RATIO = 2'd1,
        CAUSE_RUN   = 2'd2
    } cause_t;

    typedef enum logic [1:0] {
        REG_ROUTE_PCT         = 2'd0,
        REG_PROMOTE_DELAY_MS  = 2'd1,
        REG_MAX_FAILURE_RATIO = 2'd2,
        REG_MAX_FAILURE_RUN   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [PCT_W-1:0]   route_pct;
        logic [DELAY_W-1:0] promote_delay_ms;
        logic [RATIO_W-1:0] max_failure_ratio;
        logic [RUN_W-1:0]   max_failure_run;
    } cfg_t;

    // Event fields that travel alongside the hash reduction
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic                  outcome_ok;
        logic [TIME_W-1:0]     time_ms;
        logic                  gen_nonzero;
    } item_t;

    // Result item, status in the lowest bits
    typedef struct packed {
        logic     trial_active;
        cause_t   rollback_cause;
        verdict_t verdict;
        logic     route_to_canary;
        status_t  status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/crm_cfg_regs.sv =====
// APB register file holding the monitor's configuration.
`timescale 1ns / 1ps
`default_nettype none

module crm_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [crm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [crm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output crm_pkg::cfg_t                         cfg
);

    crm_pkg::cfg_t     cfg_reg;
    crm_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = crm_pkg::reg_idx_t'(paddr[crm_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.route_pct         <= crm_pkg::PCT_RST;
            cfg_reg.promote_delay_ms  <= crm_pkg::DELAY_RST;
            cfg_reg.max_failure_ratio <= crm_pkg::RATIO_RST;
            cfg_reg.max_failure_run   <= crm_pkg::RUN_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                crm_pkg::REG_ROUTE_PCT:
                    cfg_reg.route_pct <= pwdata[crm_pkg::PCT_W-1:0];
                crm_pkg::REG_PROMOTE_DELAY_MS:
                    cfg_reg.promote_delay_ms <= pwdata[crm_pkg::DELAY_W-1:0];
                crm_pkg::REG_MAX_FAILURE_RATIO:
                    cfg_reg.max_failure_ratio <= pwdata[crm_pkg::RATIO_W-1:0];
                crm_pkg::REG_MAX_FAILURE_RUN:
                    cfg_reg.max_failure_run <= pwdata[crm_pkg::RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            crm_pkg::REG_ROUTE_PCT:
                prdata = crm_pkg::APB_DATA_W'(cfg_reg.route_pct);
            crm_pkg::REG_PROMOTE_DELAY_MS:
                prdata = crm_pkg::APB_DATA_W'(cfg_reg.promote_delay_ms);
            crm_pkg::REG_MAX_FAILURE_RATIO:
                prdata = crm_pkg::APB_DATA_W'(cfg_reg.max_failure_ratio);
            crm_pkg::REG_MAX_FAILURE_RUN:
                prdata = crm_pkg::APB_DATA_W'(cfg_reg.max_failure_run);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/crm_key_mod.sv =====
// Two-stage pipeline reducing the 64-bit request hash modulo 100.
`timescale 1ns / 1ps
`default_nettype none

module crm_key_mod (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire crm_pkg::item_t                in_item,
    input  wire logic [crm_pkg::KEY_W-1:0]     in_key,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output crm_pkg::item_t                     out_item,
    output logic      [crm_pkg::RES_W-1:0]     out_res
);

    localparam int PROD_W = crm_pkg::FOLD_W + crm_pkg::RECIP_W;

    logic                           v1_reg;
    crm_pkg::item_t                 item1_reg;
    logic [crm_pkg::FOLD_W-1:0]     t1_reg;
    logic                           v2_reg;
    crm_pkg::item_t                 item2_reg;
    logic [crm_pkg::FOLD_W-1:0]     t2_reg;
    logic [crm_pkg::QUOT_W-1:0]     q2_reg;

    logic                           ready1;
    logic                           ready2;
    logic [crm_pkg::FOLD_SUM_W-1:0] sum16;
    logic [crm_pkg::FOLD_W-1:0]     t1_next;
    logic [PROD_W-1:0]              prod;
    logic [crm_pkg::QUOT_W-1:0]     q2_next;
    logic [crm_pkg::FOLD_W-1:0]     rem;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // Weight each 16-bit chunk by 2^(16k) mod 100, then fold the top 12 bits once more
    assign sum16 = crm_pkg::FOLD_SUM_W'(in_key[15:0])
                 + crm_pkg::FOLD_SUM_W'(in_key[31:16]) * crm_pkg::FOLD_16
                 + crm_pkg::FOLD_SUM_W'(in_key[47:32]) * crm_pkg::FOLD_32
                 + crm_pkg::FOLD_SUM_W'(in_key[63:48]) * crm_pkg::FOLD_48;
    assign t1_next = crm_pkg::FOLD_W'(sum16[11:0])
                   + crm_pkg::FOLD_W'(sum16[crm_pkg::FOLD_SUM_W-1:12]) * crm_pkg::FOLD_12;

    // Exact quotient for any 19-bit value
    assign prod    = PROD_W'(t1_reg) * PROD_W'(crm_pkg::RECIP_100);
    assign q2_next = prod[crm_pkg::RECIP_SHIFT +: crm_pkg::QUOT_W];

    assign rem = t2_reg - crm_pkg::FOLD_W'(q2_reg) * crm_pkg::MOD_DIV;

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
    assign out_res   = rem[crm_pkg::RES_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            item1_reg <= in_item;
            t1_reg    <= t1_next;
        end
        if (ready2 && v1_reg)
        begin
            item2_reg <= item1_reg;
            t2_reg    <= t1_reg;
            q2_reg    <= q2_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/crm_trial_core.sv =====
// Trial state, event decoding and the result register.
`timescale 1ns / 1ps
`default_nettype none

module crm_trial_core #(
    parameter int COUNT_WIDTH = crm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire crm_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire crm_pkg::item_t                in_item,
    input  wire logic [crm_pkg::RES_W-1:0]     in_res,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output crm_pkg::result_t                   out_result
);

    localparam int NCHUNK = (COUNT_WIDTH + 31) / 32;
    localparam int PADW   = NCHUNK * 32;
    localparam int PP_W   = crm_pkg::RATIO_W + 32;
    localparam int PROD_W = PADW + crm_pkg::RATIO_W;
    localparam int CMPW   = (COUNT_WIDTH > crm_pkg::RUN_W) ? COUNT_WIDTH : crm_pkg::RUN_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                          armed_reg,   armed_next;
    logic [crm_pkg::TIME_W-1:0]    start_reg,   start_next;
    logic [COUNT_WIDTH-1:0]        routed_reg,  routed_next;
    logic [COUNT_WIDTH-1:0]        success_reg, success_next;
    logic [COUNT_WIDTH-1:0]        failure_reg, failure_next;
    logic [COUNT_WIDTH-1:0]        run_reg,     run_next;
    crm_pkg::cause_t               cause_reg,   cause_next;
    logic                          out_valid_reg;
    crm_pkg::result_t              out_reg;

    crm_pkg::result_t              result;
    logic                          fire;
    logic                          cnt_full;
    logic                          run_hit;
    logic                          ratio_hit;
    logic                          time_hit;
    logic [PADW-1:0]               routed_pad;
    logic [PP_W-1:0]               pp [NCHUNK];
    logic [PROD_W-1:0]             rhs;
    logic [PROD_W-1:0]             lhs;
    logic [crm_pkg::TIME_W-1:0]    elapsed;

    assign in_ready   = !out_valid_reg || out_ready;
    assign fire       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign cnt_full = (routed_reg == CNT_MAX) || (success_reg == CNT_MAX)
                   || (failure_reg == CNT_MAX);
    assign run_hit  = CMPW'(run_reg) >= CMPW'(cfg.max_failure_run);

    // failures * 65536 > ratio * routed, the product split into 17x32 slices
    assign routed_pad = PADW'(routed_reg);
    assign lhs        = PROD_W'({failure_reg, {crm_pkg::RATIO_SHIFT{1'b0}}});

    always_comb
    begin
        rhs = '0;
        for (int k = 0; k < NCHUNK; k++)
        begin
            pp[k] = PP_W'(cfg.max_failure_ratio) * PP_W'(routed_pad[32*k +: 32]);
            rhs   = rhs + (PROD_W'(pp[k]) << (32 * k));
        end
    end

    assign ratio_hit = (routed_reg != '0) && (lhs > rhs);
    assign elapsed   = in_item.time_ms - start_reg;
    assign time_hit  = (in_item.time_ms >= start_reg)
                    && (elapsed >= crm_pkg::TIME_W'(cfg.promote_delay_ms));

    always_comb
    begin
        armed_next   = armed_reg;
        start_next   = start_reg;
        routed_next  = routed_reg;
        success_next = success_reg;
        failure_next = failure_reg;
        run_next     = run_reg;
        cause_next   = cause_reg;
        result.status          = crm_pkg::ST_OK;
        result.route_to_canary = 1'b0;
        result.verdict         = crm_pkg::VERDICT_KEEP;

        unique case (in_item.req_type)
            crm_pkg::REQ_ROUTE:
            begin
                result.route_to_canary = armed_reg && (in_res < cfg.route_pct);
            end
            crm_pkg::REQ_RECORD:
            begin
                if (!armed_reg)
                begin
                    result.status = crm_pkg::ST_NOT_ACTIVE;
                end
                else if (cnt_full)
                begin
                    result.status = crm_pkg::ST_COUNTER_FULL;
                end
                else
                begin
                    routed_next = routed_reg + COUNT_WIDTH'(1);
                    if (in_item.outcome_ok)
                    begin
                        success_next = success_reg + COUNT_WIDTH'(1);
                        run_next     = '0;
                    end
                    else
                    begin
                        failure_next = failure_reg + COUNT_WIDTH'(1);
                        if (run_reg != CNT_MAX)
                        begin
                            run_next = run_reg + COUNT_WIDTH'(1);
                        end
                    end
                end
            end
            crm_pkg::REQ_DECIDE:
            begin
                if (armed_reg)
                begin
                    if (run_hit)
                    begin
                        cause_next     = crm_pkg::CAUSE_RUN;
                        result.verdict = crm_pkg::VERDICT_ROLLBACK;
                    end
                    else if (ratio_hit)
                    begin
                        cause_next     = crm_pkg::CAUSE_RATIO;
                        result.verdict = crm_pkg::VERDICT_ROLLBACK;
                    end
                    else if (time_hit)
                    begin
                        result.verdict = crm_pkg::VERDICT_PROMOTE;
                    end
                end
            end
            crm_pkg::REQ_START:
            begin
                if (!in_item.gen_nonzero)
                begin
                    result.status = crm_pkg::ST_INVALID_ARG;
                end
                else
                begin
                    armed_next   = 1'b1;
                    start_next   = in_item.time_ms;
                    routed_next  = '0;
                    success_next = '0;
                    failure_next = '0;
                    run_next     = '0;
                    cause_next   = crm_pkg::CAUSE_NONE;
                end
            end
            crm_pkg::REQ_STOP:
            begin
                armed_next = 1'b0;
            end
            default:
            begin
                result.status = crm_pkg::ST_INVALID_ARG;
            end
        endcase

        result.rollback_cause = cause_next;
        result.trial_active   = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            start_reg     <= '0;
            routed_reg    <= '0;
            success_reg   <= '0;
            failure_reg   <= '0;
            run_reg       <= '0;
            cause_reg     <= crm_pkg::CAUSE_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                armed_reg   <= armed_next;
                start_reg   <= start_next;
                routed_reg  <= routed_next;
                success_reg <= success_next;
                failure_reg <= failure_next;
                run_reg     <= run_next;
                cause_reg   <= cause_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/canary_rollout_monitor.sv =====
// Top level of the canary rollout monitor: input register, hash pipeline, trial core.
// Usage
//   Events enter on the s_axis channel: s_axis_tuser carries the request type
//   (route, record, decide, start, stop) and s_axis_tdata the request hash,
//   the outcome flag, the time in ms and the candidate generation. Each event
//   gives exactly one result item on m_axis (status, route answer, verdict,
//   stored rollback cause, armed flag). The four limits sit in an APB register
//   file at byte addresses 0, 4, 8 and 12; write them only while no event is
//   in flight.
// Timing
//   An accepted item passes the input register, the hash fold stage and the
//   quotient stage, then the trial update writes its result into the result
//   register behind m_axis_tvalid. Throughput is one item per cycle while
//   m_axis_tready stays high, set by the trial update, which sees the state
//   left by the item just ahead of it.
// Reset
//   rst_n clears the trial (disarmed, counters and cause zero), empties every
//   stage and restores the register reset values.
// Back-pressure
//   Each stage holds its item while the next one is full; the input side keeps
//   taking items until every stage is occupied behind a stalled result.
`timescale 1ns / 1ps
`default_nettype none

module canary_rollout_monitor #(
    parameter int COUNT_WIDTH = crm_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Event input
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [63:0] request_key, [64] outcome_ok, [128:65] time_ms,
    // [192:129] generation_id, [199:193] zero
    input  wire logic [crm_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [2:0] req_type
    input  wire logic [crm_pkg::REQ_TYPE_W-1:0]      s_axis_tuser,
    // Result output
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [1:0] status, [2] route_to_canary, [4:3] verdict,
    // [6:5] rollback_cause, [7] trial_active
    output logic      [crm_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [crm_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [crm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [crm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                     pready
);

    crm_pkg::cfg_t                   cfg;

    logic                            v0_reg;
    crm_pkg::item_t                  item0_reg;
    logic [crm_pkg::KEY_W-1:0]       key0_reg;
    crm_pkg::item_t                  item0_next;

    logic                            km_in_ready;
    logic                            km_out_valid;
    crm_pkg::item_t                  km_out_item;
    logic [crm_pkg::RES_W-1:0]       km_out_res;
    logic                            core_in_ready;
    crm_pkg::result_t                core_result;

    // Unpack the event; keep only whether the generation is zero
    assign item0_next.req_type    = crm_pkg::req_t'(s_axis_tuser);
    assign item0_next.outcome_ok  = s_axis_tdata[64];
    assign item0_next.time_ms     = s_axis_tdata[128:65];
    assign item0_next.gen_nonzero = |s_axis_tdata[192:129];

    // Take a new item whenever the input register is free or moves on
    assign s_axis_tready = !v0_reg || km_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            v0_reg <= s_axis_tvalid;
        end
    end

    // Hold the payload until the hash stage takes it
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item0_reg <= item0_next;
            key0_reg  <= s_axis_tdata[crm_pkg::KEY_W-1:0];
        end
    end

    crm_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Reduce the hash modulo 100 ahead of the trial update
    crm_key_mod u_key_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_ready  (km_in_ready),
        .in_item   (item0_reg),
        .in_key    (key0_reg),
        .out_valid (km_out_valid),
        .out_ready (core_in_ready),
        .out_item  (km_out_item),
        .out_res   (km_out_res)
    );

    // Advance the trial state and register one result per event
    crm_trial_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_trial_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (km_out_valid),
        .in_ready   (core_in_ready),
        .in_item    (km_out_item),
        .in_res     (km_out_res),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (core_result)
    );

    assign m_axis_tdata = core_result;

endmodule

`default_nettype wire

// ===== verif/canary_rollout_monitor_test.sv =====
// Self-checking testbench of the canary rollout monitor: directed table, random trials.
`timescale 1ns / 1ps

module canary_rollout_monitor_test;

    // Request types the block rejects as invalid arguments
    localparam logic [crm_pkg::REQ_TYPE_W-1:0] REQ_SPARE_A = 3'd5;
    localparam logic [crm_pkg::REQ_TYPE_W-1:0] REQ_SPARE_C = 3'd7;

    localparam logic [63:0] COUNT_TOP       = 64'h0000_0000_FFFF_FFFF;
    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 53;
    localparam int          WATCHDOG_CYCLES = 2000;
    localparam int          TAIL_CYCLES     = 8;

    typedef struct {
        logic [crm_pkg::REQ_TYPE_W-1:0] kind;
        logic [63:0]                    key;
        logic                           ok;
        logic [63:0]                    now_ms;
        logic [63:0]                    gen;
        bit                             typed;
        crm_pkg::result_t               want;
    } stim_row_t;

    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           s_valid = 1'b0;
    logic [crm_pkg::S_TDATA_W-1:0]  s_data  = '0;
    logic [crm_pkg::REQ_TYPE_W-1:0] s_user  = '0;
    wire                            s_ready;
    wire                            m_valid;
    logic                           m_ready = 1'b0;
    wire  [crm_pkg::M_TDATA_W-1:0]  m_data;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [crm_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [crm_pkg::APB_DATA_W-1:0] pwdata  = '0;
    wire  [crm_pkg::APB_DATA_W-1:0] prdata;
    wire                            pready;

    // Trial state and limits as the block should hold them
    logic            trial_on;
    logic [63:0]     trial_gen;
    logic [63:0]     trial_t0;
    logic [63:0]     n_routed;
    logic [63:0]     n_ok;
    logic [63:0]     n_fail;
    logic [63:0]     fail_streak;
    crm_pkg::cause_t held_cause;
    logic [63:0]     pct_cfg;
    logic [63:0]     delay_cfg;
    logic [63:0]     ratio_cfg;
    logic [63:0]     run_cfg;

    crm_pkg::result_t awaited_results[$];
    stim_row_t        plan[$];
    int               mismatches   = 0;
    int               results_seen = 0;
    int               moves        = 0;
    bit               steady       = 1'b0;
    int               hold_left    = 0;

    canary_rollout_monitor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        // [63:0] request_key, [64] outcome_ok, [128:65] time_ms,
        // [192:129] generation_id, [199:193] zero
        .s_axis_tdata  (s_data),
        // [2:0] req_type
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        // [1:0] status, [2] route_to_canary, [4:3] verdict,
        // [6:5] rollback_cause, [7] trial_active
        .m_axis_tdata  (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the trial by one item and return the result it must produce.
    function automatic crm_pkg::result_t apply_item(
        input logic [crm_pkg::REQ_TYPE_W-1:0] kind, input logic [63:0] key,
        input logic ok, input logic [63:0] now_ms, input logic [63:0] gen);
        crm_pkg::result_t r;
        r = '0;
        r.status  = crm_pkg::ST_OK;
        r.verdict = crm_pkg::VERDICT_KEEP;
        case (kind)
            crm_pkg::REQ_ROUTE:
                // hash mod 100 against the live percent; nothing routes while disarmed
                if (trial_on && (key % 64'd100) < pct_cfg)
                    r.route_to_canary = 1'b1;
            crm_pkg::REQ_RECORD:
                if (!trial_on)
                    r.status = crm_pkg::ST_NOT_ACTIVE;
                else if (n_routed >= COUNT_TOP || n_ok >= COUNT_TOP || n_fail >= COUNT_TOP)
                    r.status = crm_pkg::ST_COUNTER_FULL;
                else
                begin
                    n_routed = n_routed + 1;
                    if (ok)
                    begin
                        n_ok        = n_ok + 1;
                        fail_streak = '0;
                    end
                    else
                    begin
                        n_fail = n_fail + 1;
                        if (fail_streak < COUNT_TOP)
                            fail_streak = fail_streak + 1;
                    end
                end
            crm_pkg::REQ_DECIDE:
                if (trial_on)
                begin
                    // run limit first, then the exact ratio test, then elapsed time
                    if (fail_streak >= run_cfg)
                    begin
                        held_cause = crm_pkg::CAUSE_RUN;
                        r.verdict  = crm_pkg::VERDICT_ROLLBACK;
                    end
                    else if (n_routed != 0
                             && (n_fail << crm_pkg::RATIO_SHIFT) > ratio_cfg * n_routed)
                    begin
                        held_cause = crm_pkg::CAUSE_RATIO;
                        r.verdict  = crm_pkg::VERDICT_ROLLBACK;
                    end
                    else if (now_ms >= trial_t0 && now_ms - trial_t0 >= delay_cfg)
                        r.verdict = crm_pkg::VERDICT_PROMOTE;
                end
            crm_pkg::REQ_START:
                if (gen == '0)
                    r.status = crm_pkg::ST_INVALID_ARG;
                else
                begin
                    trial_on    = 1'b1;
                    trial_gen   = gen;
                    trial_t0    = now_ms;
                    n_routed    = '0;
                    n_ok        = '0;
                    n_fail      = '0;
                    fail_streak = '0;
                    held_cause  = crm_pkg::CAUSE_NONE;
                end
            crm_pkg::REQ_STOP:
                trial_on = 1'b0;
            default:
                r.status = crm_pkg::ST_INVALID_ARG;
        endcase
        r.rollback_cause = held_cause;
        r.trial_active   = trial_on;
        return r;
    endfunction

    function automatic crm_pkg::result_t res(input crm_pkg::status_t s, input logic route,
                                             input crm_pkg::verdict_t v,
                                             input crm_pkg::cause_t c, input logic active);
        crm_pkg::result_t r;
        r.status          = s;
        r.route_to_canary = route;
        r.verdict         = v;
        r.rollback_cause  = c;
        r.trial_active    = active;
        return r;
    endfunction

    // Mostly no gap, some short ones, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("MISMATCH at %0t, result %0d, %s: got %0h, want %0h",
                 $time, results_seen, what, got, want);
    endtask

    task automatic check_result(input crm_pkg::result_t got);
        crm_pkg::result_t want;
        results_seen++;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("result with nothing awaited", got, '0);
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.route_to_canary !== want.route_to_canary)
            report_mismatch("route_to_canary", got.route_to_canary, want.route_to_canary);
        if (got.verdict !== want.verdict)
            report_mismatch("verdict", got.verdict, want.verdict);
        if (got.rollback_cause !== want.rollback_cause)
            report_mismatch("rollback_cause", got.rollback_cause, want.rollback_cause);
        if (got.trial_active !== want.trial_active)
            report_mismatch("trial_active", got.trial_active, want.trial_active);
    endtask

    // Write a limit, then read it back in the next transfer.
    task automatic write_limit(input crm_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] back;
        logic [31:0] kept;
        case (idx)
            crm_pkg::REG_ROUTE_PCT:         kept = value & 32'h7F;
            crm_pkg::REG_MAX_FAILURE_RATIO: kept = value & 32'h1_FFFF;
            default:                        kept = value;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // written at this edge; hold psel and turn the transfer into a read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (back !== kept)
            report_mismatch("register readback", back, kept);
        case (idx)
            crm_pkg::REG_ROUTE_PCT:         pct_cfg   = kept;
            crm_pkg::REG_PROMOTE_DELAY_MS:  delay_cfg = kept;
            crm_pkg::REG_MAX_FAILURE_RATIO: ratio_cfg = kept;
            default:                        run_cfg   = kept;
        endcase
        // leave the bus idle before the next transfer
        @(posedge clk);
    endtask

    // Predict, then present the item until the block takes it.
    task automatic send_item(input logic [crm_pkg::REQ_TYPE_W-1:0] kind,
                             input logic [63:0] key, input logic ok,
                             input logic [63:0] now_ms, input logic [63:0] gen,
                             input bit typed, input crm_pkg::result_t want);
        int               gap;
        crm_pkg::result_t predicted;
        gap       = pick_gap();
        predicted = apply_item(kind, key, ok, now_ms, gen);
        awaited_results.push_back(typed ? want : predicted);
        if (gap != 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {7'd0, gen, now_ms, ok, key};
        do
            @(posedge clk);
        while (!s_ready);
        moves++;
    endtask

    task automatic add_row(input logic [crm_pkg::REQ_TYPE_W-1:0] kind,
                           input logic [63:0] key, input logic ok,
                           input logic [63:0] now_ms, input logic [63:0] gen,
                           input bit typed, input crm_pkg::result_t want);
        stim_row_t row;
        row.kind   = kind;
        row.key    = key;
        row.ok     = ok;
        row.now_ms = now_ms;
        row.gen    = gen;
        row.typed  = typed;
        row.want   = want;
        plan.push_back(row);
    endtask

    // Random trials: mostly a start while disarmed, then routes, records and decides; a little noise.
    task automatic run_trials(input int count);
        int                             k;
        int                             pick;
        int                             fail_pct;
        logic [crm_pkg::REQ_TYPE_W-1:0] kind;
        logic [63:0]                    key;
        logic [63:0]                    now_ms;
        logic [63:0]                    gen;
        logic                           ok;
        fail_pct = $urandom_range(0, 50);
        for (k = 0; k < count; k++)
        begin
            if (k % 24 == 0)
                steady = ($urandom_range(0, 3) == 0);
            // fields the item does not use carry random values as well
            key    = {$urandom, $urandom};
            now_ms = {$urandom, $urandom};
            gen    = {$urandom, $urandom};
            ok     = $urandom_range(0, 1);
            pick   = $urandom_range(0, 99);
            if ((!trial_on && pick < 75) || pick >= 96)
            begin
                kind = crm_pkg::REQ_START;
                if ($urandom_range(0, 9) == 0)
                    gen = '0;
                else if ($urandom_range(0, 3) == 0)
                    gen = 64'($urandom_range(1, 9));
                if ($urandom_range(0, 7) != 0)
                    now_ms = {32'd0, $urandom};
                fail_pct = $urandom_range(0, 50);
            end
            else if (pick < 35)
                kind = crm_pkg::REQ_ROUTE;
            else if (pick < 70)
            begin
                kind = crm_pkg::REQ_RECORD;
                ok   = ($urandom_range(0, 99) >= fail_pct);
            end
            else if (pick < 88)
            begin
                kind = crm_pkg::REQ_DECIDE;
                // aim around the promotion edge, and sometimes before the start
                case ($urandom_range(0, 5))
                    0: now_ms = trial_t0 + delay_cfg - 64'd1;
                    1: now_ms = trial_t0 + delay_cfg;
                    2: now_ms = trial_t0 + delay_cfg + 64'($urandom_range(1, 40));
                    3: now_ms = trial_t0 + 64'($urandom_range(0, 60));
                    4: now_ms = trial_t0 - 64'($urandom_range(1, 60));
                    default: ;
                endcase
            end
            else if (pick < 92)
                kind = crm_pkg::REQ_STOP;
            else
                kind = crm_pkg::REQ_TYPE_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
            send_item(kind, key, ok, now_ms, gen, 1'b0, '0);
        end
        steady = 1'b0;
    endtask

    // Drop valid and hold until every awaited result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check each accepted item, stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_valid && m_ready)
            begin
                moves++;
                check_result(crm_pkg::result_t'(m_data));
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                hold_left = pick_gap();
                m_ready <= (hold_left == 0);
            end
            else
                m_ready <= 1'b1;
        end
    end

    // End the run if nothing moves on either side for too long.
    initial
    begin
        int quiet;
        int last;
        quiet = 0;
        last  = 0;
        while (quiet < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if (moves != last)
            begin
                last  = moves;
                quiet = 0;
            end
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] ph_pct[PHASES];
        logic [31:0] ph_delay[PHASES];
        logic [31:0] ph_ratio[PHASES];
        logic [31:0] ph_run[PHASES];
        int          p;
        int          i;

        trial_on    = 1'b0;
        trial_gen   = '0;
        trial_t0    = '0;
        n_routed    = '0;
        n_ok        = '0;
        n_fail      = '0;
        fail_streak = '0;
        held_cause  = crm_pkg::CAUSE_NONE;
        pct_cfg     = crm_pkg::PCT_RST;
        delay_cfg   = crm_pkg::DELAY_RST;
        ratio_cfg   = crm_pkg::RATIO_RST;
        run_cfg     = crm_pkg::RUN_RST;

        // Limit settings per phase: extremes first, then fixed middle values, then random ones
        ph_pct[0] = 32'd0;   ph_delay[0] = 32'd1;          ph_ratio[0] = 32'd0;
        ph_run[0] = 32'd0;
        ph_pct[1] = 32'd100; ph_delay[1] = 32'hFFFF_FFFF;  ph_ratio[1] = 32'd65536;
        ph_run[1] = 32'hFFFF_FFFF;
        ph_pct[2] = 32'd127; ph_delay[2] = 32'd50;         ph_ratio[2] = 32'h1_FFFF;
        ph_run[2] = 32'd1;
        ph_pct[3] = 32'd1;   ph_delay[3] = 32'd20;         ph_ratio[3] = 32'd3277;
        ph_run[3] = 32'd3;
        ph_pct[4] = 32'd50;  ph_delay[4] = 32'd100;        ph_ratio[4] = 32'd16384;
        ph_run[4] = 32'd4;
        for (p = 5; p < PHASES; p++)
        begin
            ph_pct[p]   = (p == 5) ? $urandom : $urandom_range(1, 100);
            ph_delay[p] = $urandom_range(1, 300);
            ph_ratio[p] = (p == 5) ? $urandom : $urandom_range(1000, 40000);
            ph_run[p]   = $urandom_range(1, 8);
        end

        // Directed items under the reset limits: percent 5, delay 30000,
        // ratio 3277, run 3.
        add_row(crm_pkg::REQ_ROUTE, 64'd3, 1'b0, '0, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_NONE, 1'b0));
        add_row(crm_pkg::REQ_RECORD, '0, 1'b1, '0, '0, 1'b1,
                res(crm_pkg::ST_NOT_ACTIVE, 1'b0, crm_pkg::VERDICT_KEEP,
                    crm_pkg::CAUSE_NONE, 1'b0));
        add_row(crm_pkg::REQ_DECIDE, '0, 1'b0, '1, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_NONE, 1'b0));
        add_row(crm_pkg::REQ_STOP, '0, 1'b0, '0, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_NONE, 1'b0));
        // zero generation is refused
        add_row(crm_pkg::REQ_START, '0, 1'b0, 64'd77, '0, 1'b1,
                res(crm_pkg::ST_INVALID_ARG, 1'b0, crm_pkg::VERDICT_KEEP,
                    crm_pkg::CAUSE_NONE, 1'b0));
        for (i = REQ_SPARE_A; i <= REQ_SPARE_C; i++)
            add_row(crm_pkg::REQ_TYPE_W'(i), '1, 1'b1, '1, '1, 1'b1,
                    res(crm_pkg::ST_INVALID_ARG, 1'b0, crm_pkg::VERDICT_KEEP,
                        crm_pkg::CAUSE_NONE, 1'b0));
        add_row(crm_pkg::REQ_START, '0, 1'b0, 64'd1000, '1, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_NONE, 1'b1));
        add_row(crm_pkg::REQ_ROUTE, '0, 1'b0, '0, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b1, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_NONE, 1'b1));
        // all-ones hash is 15 mod 100, above the percent
        add_row(crm_pkg::REQ_ROUTE, '1, 1'b0, '0, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_NONE, 1'b1));
        add_row(crm_pkg::REQ_ROUTE, 64'd104, 1'b0, '0, '0, 1'b0, '0);
        add_row(crm_pkg::REQ_RECORD, '0, 1'b1, '0, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_NONE, 1'b1));
        for (i = 0; i < 3; i++)
            add_row(crm_pkg::REQ_RECORD, '0, 1'b0, '0, '0, 1'b1,
                    res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP,
                        crm_pkg::CAUSE_NONE, 1'b1));
        // three failures in a row reach the run limit
        add_row(crm_pkg::REQ_DECIDE, '0, 1'b0, 64'd1000, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_ROLLBACK,
                    crm_pkg::CAUSE_RUN, 1'b1));
        add_row(crm_pkg::REQ_RECORD, '0, 1'b1, '0, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_RUN, 1'b1));
        // run broken, but 3 of 5 failed is far above the ratio
        add_row(crm_pkg::REQ_DECIDE, '0, 1'b0, 64'd1000, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_ROLLBACK,
                    crm_pkg::CAUSE_RATIO, 1'b1));
        // stop keeps the stored cause
        add_row(crm_pkg::REQ_STOP, '0, 1'b0, '0, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_RATIO, 1'b0));
        add_row(crm_pkg::REQ_DECIDE, '0, 1'b0, '1, '0, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_RATIO, 1'b0));
        add_row(crm_pkg::REQ_START, '0, 1'b0, '1, 64'd1, 1'b1,
                res(crm_pkg::ST_OK, 1'b0, crm_pkg::VERDICT_KEEP, crm_pkg::CAUSE_NONE, 1'b1));
        // time before the start never promotes
        add_row(crm_pkg::REQ_DECIDE, '0, 1'b0, '0, '0, 1'b0, '0);
        // re-arm while armed, then either side of the promotion edge
        add_row(crm_pkg::REQ_START, '0, 1'b0, '0, 64'd2, 1'b0, '0);
        add_row(crm_pkg::REQ_DECIDE, '0, 1'b0, 64'd29999, '0, 1'b0, '0);
        add_row(crm_pkg::REQ_DECIDE, '0, 1'b0, 64'd30000, '0, 1'b0, '0);
        add_row(crm_pkg::REQ_DECIDE, '0, 1'b0, '1, '0, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].kind, plan[i].key, plan[i].ok, plan[i].now_ms, plan[i].gen,
                      plan[i].typed, plan[i].want);

        for (p = 0; p < PHASES; p++)
        begin
            // limits change only with the block empty
            drain();
            write_limit(crm_pkg::REG_ROUTE_PCT, ph_pct[p]);
            write_limit(crm_pkg::REG_PROMOTE_DELAY_MS, ph_delay[p]);
            write_limit(crm_pkg::REG_MAX_FAILURE_RATIO, ph_ratio[p]);
            write_limit(crm_pkg::REG_MAX_FAILURE_RUN, ph_run[p]);
            run_trials(ITEMS_PER_PHASE);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
